// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the moving product mean block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define WPM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define WPM_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/wpm_pkg.sv =====
// ----------------------------------------------------------------------------
// wpm_pkg
// Types and constants for the windowed product mean block.
// ----------------------------------------------------------------------------
package wpm_pkg;

	localparam int WINDOW_MAX = 256;
	localparam int ADDR_W     = $clog2(WINDOW_MAX);
	localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
	localparam int SAMPLE_W   = 24;
	localparam int PROD_W     = 48;
	localparam int SUM_W      = 56;
	localparam int COV_W      = 48;
	localparam int USED_W     = 9;
	localparam int WIN_W      = 9;
	localparam int DCNT_W     = $clog2(SUM_W + 1);
	localparam int DATA_W     = 32;
	localparam int PADDR_W    = 3;

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(20);
	localparam logic [PADDR_W-3:0] REG_WINDOW = '0;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_a;
		logic signed [SAMPLE_W-1:0] sample_b;
	} sample_t;

	typedef struct packed {
		logic signed [COV_W-1:0] covariance;
		logic [USED_W-1:0]       samples_used;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SUM,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic write_ring;
		logic sum_run;
		logic div_load;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic sum_done;
		logic div_done;
		logic out_full;
	} status_t;

endpackage

// ===== sv/windowed_product_mean_core.sv =====
// ----------------------------------------------------------------------------
// windowed_product_mean_core
// Moving mean of sample products over a programmable window of recent requests.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                  Payload
// sample    in   sample_valid/sample_ready  sample_t (sample_a, sample_b)
// result    out  result_valid/result_ready  result_t (covariance, samples_used)
// apb       in   psel/penable/pwrite        window_length at byte address 0
//
// n = samples averaged (1..256). A new request is taken only after the previous
// result has been loaded into the output register. The sum is re-formed from
// the product ring at one RAM read per cycle, then a restoring divider forms
// the 56-bit quotient. No clearing pass after reset.
// A new request is taken while the previous result waits in the output
// register; a stalled result holds the sequencer only at the final load.
// ----------------------------------------------------------------------------
module windowed_product_mean_core
	import wpm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  sample_t            sample,
	output logic               result_valid,
	input  logic               result_ready,
	output result_t            result
);

	logic [WIN_W-1:0] window_q;
	cmd_t             cmd;
	status_t          status;
	logic             reg_hit;

	// word 0 holds window_length; other words read zero and ignore writes
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_WINDOW);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? DATA_W'(window_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			window_q <= pwdata[WIN_W-1:0];
		end
	end

	wpm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	wpm_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sample       (sample),
		.window       (window_q),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== sv/wpm_ram.sv =====
// ----------------------------------------------------------------------------
// wpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/wpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// wpm_ctrl
// Sequencer: accept, ring write, windowed sum, serial divide, result load.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wpm_ctrl
	import wpm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_ready,
	input  logic    result_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		sample_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// a finished result may still sit in the output register
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.write_ring = 1'b1;
				state_d        = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_run = 1'b1;
				if (status.sum_done) begin
					cmd.div_load = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_DONE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_DONE: begin
				if (!status.out_full || result_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`WPM_ASSERT(a_load_after_div, clk, arst_n, cmd.load_out |-> status.div_done, "result loaded before divide finished")
	`WPM_ASSERT(a_accept_to_write, clk, arst_n, (sample_valid && sample_ready) |=> (state_q == ST_WRITE), "accepted request not written")

endmodule

// ===== sv/wpm_datapath.sv =====
// ----------------------------------------------------------------------------
// wpm_datapath
// Multiplier, product ring, windowed accumulator, serial divider, output reg.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wpm_datapath
	import wpm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output status_t          status,
	input  sample_t          sample,
	input  logic [WIN_W-1:0] window,
	output logic             result_valid,
	input  logic             result_ready,
	output result_t          result
);

	logic signed [PROD_W-1:0] prod_q;
	logic [ADDR_W-1:0]        slot_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         n_q;
	logic [ADDR_W-1:0]        rd_addr_q;
	logic [CNT_W-1:0]         issue_left_q;
	logic                     pend_s1;
	logic signed [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]         quo_q;
	logic [CNT_W-1:0]         rem_q;
	logic                     neg_q;
	logic [DCNT_W-1:0]        div_cnt_q;
	logic                     out_valid_q;
	result_t                  out_q;

	logic [CNT_W-1:0]         count_next;
	logic [CNT_W-1:0]         eff_win;
	logic [CNT_W-1:0]         n_next;
	logic                     rd_en;
	logic [PROD_W-1:0]        rd_data;
	logic [CNT_W:0]           rem_shift;
	logic [CNT_W:0]           rem_diff;
	logic signed [SUM_W:0]    q_full;
	logic                     q_ovf;
	logic signed [COV_W-1:0]  q_sat;

	// ring: one write per request, one read per cycle while summing
	wpm_ram #(
		.WIDTH(PROD_W),
		.DEPTH(WINDOW_MAX)
	) u_ring (
		.clk   (clk),
		.we    (cmd.write_ring),
		.waddr (slot_q),
		.wdata (prod_q),
		.re    (rd_en),
		.raddr (rd_addr_q),
		.rdata (rd_data)
	);

	always_comb begin
		count_next = (int'(count_q) < WINDOW_MAX) ? count_q + 1'b1 : count_q;
		if (window == '0) begin
			eff_win = CNT_W'(1);
		end else if (int'(window) > WINDOW_MAX) begin
			eff_win = CNT_W'(WINDOW_MAX);
		end else begin
			eff_win = CNT_W'(window);
		end
		n_next = (eff_win < count_next) ? eff_win : count_next;
	end

	assign rd_en     = cmd.sum_run && (issue_left_q != '0);
	assign rem_shift = {rem_q, quo_q[SUM_W-1]};
	assign rem_diff  = rem_shift - {1'b0, n_q};

	assign q_full = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign q_ovf  = !((&q_full[SUM_W:COV_W-1]) || !(|q_full[SUM_W:COV_W-1]));
	always_comb begin
		if (q_ovf) begin
			q_sat = q_full[SUM_W] ? {1'b1, {(COV_W-1){1'b0}}} : {1'b0, {(COV_W-1){1'b1}}};
		end else begin
			q_sat = q_full[COV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q       <= '0;
			count_q      <= '0;
			issue_left_q <= '0;
			pend_s1      <= 1'b0;
			div_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.write_ring) begin
				slot_q       <= (int'(slot_q) == WINDOW_MAX - 1) ? '0 : slot_q + 1'b1;
				count_q      <= count_next;
				issue_left_q <= n_next;
				pend_s1      <= 1'b0;
			end else if (cmd.sum_run) begin
				pend_s1 <= rd_en;
				if (rd_en) begin
					issue_left_q <= issue_left_q - 1'b1;
				end
			end
			if (cmd.div_load) begin
				div_cnt_q <= DCNT_W'(SUM_W);
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			prod_q <= sample.sample_a * sample.sample_b;
		end
		if (cmd.write_ring) begin
			n_q       <= n_next;
			rd_addr_q <= slot_q;
			sum_q     <= '0;
		end else if (cmd.sum_run) begin
			if (rd_en) begin
				// walk back from the newest product
				rd_addr_q <= (rd_addr_q == '0) ? ADDR_W'(WINDOW_MAX - 1) : rd_addr_q - 1'b1;
			end
			if (pend_s1) begin
				sum_q <= sum_q + {{(SUM_W-PROD_W){rd_data[PROD_W-1]}}, rd_data};
			end
		end
		if (cmd.div_load) begin
			neg_q <= sum_q[SUM_W-1];
			quo_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			// restoring step: remainder stays below n, quotient shifts in at the bottom
			if (!rem_diff[CNT_W]) begin
				rem_q <= rem_diff[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift[CNT_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
		if (cmd.load_out) begin
			out_q.covariance   <= q_sat;
			out_q.samples_used <= n_q[USED_W-1:0];
		end
	end

	assign status.sum_done = (issue_left_q == '0) && !pend_s1;
	assign status.div_done = (div_cnt_q == '0);
	assign status.out_full = out_valid_q;
	assign result_valid    = out_valid_q;
	assign result          = out_q;

	`WPM_ASSERT(a_div_nonzero, clk, arst_n, cmd.div_step |-> (n_q != '0), "divide by zero count")
	`WPM_ASSERT(a_issue_bound, clk, arst_n, cmd.sum_run |-> (issue_left_q <= n_q), "ring reads exceed window")
	`WPM_NEVER(a_count_bound, clk, arst_n, int'(count_q) > WINDOW_MAX, "sample count past maximum")
	`WPM_ASSERT(a_n_le_count, clk, arst_n, cmd.div_load |-> (n_q <= count_q), "window reaches unwritten entries")

endmodule
